@@ hdl/rcm_pkg.sv @@
package rcm_pkg;

   // Default matrix bounds.
   localparam int DEF_MAX_OUTPUTS = 16;
   localparam int DEF_MAX_INPUTS  = 16;

   // Width of a port count field.
   localparam int CntW = 5;

   // Operation codes.
   localparam logic [2:0] MODE_SET     = 3'd0;
   localparam logic [2:0] MODE_GET     = 3'd1;
   localparam logic [2:0] MODE_RESIZE  = 3'd2;
   localparam logic [2:0] MODE_REM_IN  = 3'd3;
   localparam logic [2:0] MODE_REM_OUT = 3'd4;
   localparam logic [2:0] MODE_ROUTE   = 3'd5;

   // Status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_REFUSED = 2'd2;

   typedef struct packed {
      logic [2:0]      mode;
      logic [3:0]      output_index;
      logic [3:0]      input_index;
      logic            bit_value;
      logic [CntW-1:0] new_output_count;
      logic [CntW-1:0] new_input_count;
   } req_type;

   typedef struct packed {
      logic            connected;
      logic [3:0]      found_output;
      logic            found_valid;
      logic            last_result;
      logic [1:0]      status;
      logic [CntW-1:0] current_outputs;
      logic [CntW-1:0] current_inputs;
   } rsp_type;

endpackage

@@ hdl/routing_crosspoint_matrix.sv @@
// Crosspoint connection matrix: one connection bit per (input, output) pair,
// with live port counts that can be resized or shrunk one port at a time.
// Request channel: req_data is taken at a rising edge where start is high
// and busy is low. One transaction is worked on at a time. busy falls on the
// edge that raises the last result strobe, so the next transaction can be
// taken at the edge that takes that last result.
// Result channel: each result appears on rsp_data for exactly one cycle with
// rsp_valid high. The receiver cannot stall, so results are never held back.
// Route gives one result per connected output in ascending order, others one.
// Set and get read the row, then write it back (set) or answer (get);
// range errors, refusals and unknown modes answer straight from idle.
// Resize and remove output sweep every row; remove input sweeps from
// input_index up to the last live row. Route loads the row, then scans
// up to the highest connected output, or answers at once if none is.
// Each row edit goes through the row memory with its registered read: it
// is a read followed by a write, and route shifts one column per cycle.
// Reset clears both live counts and marks every row as empty at once; no
// clearing pass is needed and a transaction may be accepted right after.
module routing_crosspoint_matrix #(
   parameter int MAX_OUTPUTS = rcm_pkg::DEF_MAX_OUTPUTS,
   parameter int MAX_INPUTS  = rcm_pkg::DEF_MAX_INPUTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rcm_pkg::req_type req_data,
   output logic             rsp_valid,
   output rcm_pkg::rsp_type rsp_data
);

   localparam int CntW    = rcm_pkg::CntW;
   localparam int RowAw   = $clog2(MAX_INPUTS);
   localparam int ColAw   = $clog2(MAX_OUTPUTS);
   localparam int CmpW    = (RowAw + 1 > CntW) ? RowAw + 1 : CntW;
   localparam logic [RowAw-1:0] LastRow = RowAw'(MAX_INPUTS - 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SG      = 3'd1;
   localparam logic [2:0] S_SWP_RD  = 3'd2;
   localparam logic [2:0] S_SWP_WR  = 3'd3;
   localparam logic [2:0] S_RT_LOAD = 3'd4;
   localparam logic [2:0] S_RT_SCAN = 3'd5;

   logic [2:0]             state_ff, state_in;
   rcm_pkg::req_type       req_ff, req_in;
   logic [1:0]             st_ff, st_in;
   logic [RowAw-1:0]       row_ff, row_in;
   logic                   tail_ff, tail_in;
   logic [MAX_OUTPUTS-1:0] shift_ff, shift_in;
   logic [ColAw-1:0]       col_ff, col_in;
   logic [CntW-1:0]        live_out_ff, live_out_in;
   logic [CntW-1:0]        live_in_ff, live_in_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rcm_pkg::rsp_type       rsp_data_ff, rsp_data_in;
   logic [MAX_INPUTS-1:0]  row_valid_ff, row_valid_in;

   // Row memory and its port controls.
   logic [MAX_OUTPUTS-1:0] rows_mem [MAX_INPUTS];
   logic [MAX_OUTPUTS-1:0] rd_data_ff;
   logic                   rd_hit_ff;
   logic                   rd_en;
   logic [RowAw-1:0]       rd_addr;
   logic                   wr_en;
   logic [RowAw-1:0]       wr_addr;
   logic [MAX_OUTPUTS-1:0] wr_data;

   logic [MAX_OUTPUTS-1:0] rd_row;
   logic [MAX_OUTPUTS-1:0] sel_bit;
   logic [MAX_OUTPUTS-1:0] get_row;
   logic [MAX_OUTPUTS-1:0] keep_mask;
   logic [MAX_OUTPUTS-1:0] shift_rest;
   logic                   start_acc;

   // Bits below n set, the rest clear.
   function automatic logic [MAX_OUTPUTS-1:0] low_mask(input logic [CntW-1:0] n);
      logic [MAX_OUTPUTS-1:0] m;
      for (int j = 0; j < MAX_OUTPUTS; j++) begin
         m[j] = (j < int'(n));
      end
      return m;
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign start_acc = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A row that was never written since reset reads as empty.
   assign rd_row     = rd_hit_ff ? rd_data_ff : '0;
   assign sel_bit    = {{(MAX_OUTPUTS-1){1'b0}}, 1'b1} << req_ff.output_index;
   assign get_row    = rd_row >> req_ff.output_index;
   assign keep_mask  = low_mask(CntW'(req_ff.output_index));
   assign shift_rest = shift_ff >> 1;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      st_in        = st_ff;
      row_in       = row_ff;
      tail_in      = tail_ff;
      shift_in     = shift_ff;
      col_in       = col_ff;
      live_out_in  = live_out_ff;
      live_in_in   = live_in_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = row_ff;
      wr_data      = '0;

      case (state_ff)
         S_IDLE: begin
            if (start_acc) begin
               req_in = req_data;
               st_in  = rcm_pkg::ST_OK;
               row_in = '0;
               tail_in = 1'b0;
               case (req_data.mode)
                  rcm_pkg::MODE_SET, rcm_pkg::MODE_GET: begin
                     if ({1'b0, req_data.output_index} >= live_out_ff ||
                         {1'b0, req_data.input_index} >= live_in_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in.last_result = 1'b1;
                        rsp_data_in.status = rcm_pkg::ST_RANGE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = RowAw'(req_data.input_index);
                        state_in = S_SG;
                     end
                  end
                  rcm_pkg::MODE_RESIZE: begin
                     if (32'(req_data.new_output_count) > 32'(MAX_OUTPUTS)) begin
                        req_in.new_output_count = CntW'(MAX_OUTPUTS);
                        st_in = rcm_pkg::ST_RANGE;
                     end
                     if (32'(req_data.new_input_count) > 32'(MAX_INPUTS)) begin
                        req_in.new_input_count = CntW'(MAX_INPUTS);
                        st_in = rcm_pkg::ST_RANGE;
                     end
                     state_in = S_SWP_RD;
                  end
                  rcm_pkg::MODE_REM_IN: begin
                     rsp_data_in.last_result = 1'b1;
                     if (live_out_ff == '0 || live_in_ff <= CntW'(1)) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in.status = rcm_pkg::ST_REFUSED;
                     end else if ({1'b0, req_data.input_index} >= live_in_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in.status = rcm_pkg::ST_RANGE;
                     end else begin
                        row_in   = RowAw'(req_data.input_index);
                        state_in = S_SWP_RD;
                     end
                  end
                  rcm_pkg::MODE_REM_OUT: begin
                     rsp_data_in.last_result = 1'b1;
                     if (live_out_ff <= CntW'(1) || live_in_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in.status = rcm_pkg::ST_REFUSED;
                     end else if ({1'b0, req_data.output_index} >= live_out_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in.status = rcm_pkg::ST_RANGE;
                     end else begin
                        state_in = S_SWP_RD;
                     end
                  end
                  rcm_pkg::MODE_ROUTE: begin
                     if ({1'b0, req_data.input_index} >= live_in_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in.last_result = 1'b1;
                        rsp_data_in.status = rcm_pkg::ST_RANGE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = RowAw'(req_data.input_index);
                        state_in = S_RT_LOAD;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in.last_result = 1'b1;
                     rsp_data_in.status = rcm_pkg::ST_RANGE;
                  end
               endcase
            end
         end

         // Set or get on a row that has just been read.
         S_SG: begin
            rsp_valid_in = 1'b1;
            rsp_data_in.last_result = 1'b1;
            wr_addr = RowAw'(req_ff.input_index);
            if (req_ff.mode == rcm_pkg::MODE_SET) begin
               wr_en   = 1'b1;
               wr_data = req_ff.bit_value ? (rd_row | sel_bit) : (rd_row & ~sel_bit);
               rsp_data_in.connected = req_ff.bit_value;
            end else begin
               rsp_data_in.connected = get_row[0];
            end
            state_in = S_IDLE;
         end

         // Row sweep, read half: pick the source row for row_ff.
         S_SWP_RD: begin
            rd_en   = 1'b1;
            rd_addr = row_ff;
            if (req_ff.mode == rcm_pkg::MODE_REM_IN) begin
               if ((CmpW'(row_ff) + CmpW'(1)) < CmpW'(live_in_ff)) begin
                  rd_addr = row_ff + RowAw'(1);
               end else begin
                  rd_en   = 1'b0;
                  tail_in = 1'b1;
               end
            end
            state_in = S_SWP_WR;
         end

         // Row sweep, write half: store the edited row and step on.
         S_SWP_WR: begin
            wr_en   = 1'b1;
            wr_addr = row_ff;
            state_in = S_SWP_RD;
            row_in   = row_ff + RowAw'(1);
            case (req_ff.mode)
               rcm_pkg::MODE_RESIZE: begin
                  if (CmpW'(row_ff) < CmpW'(req_ff.new_input_count)) begin
                     wr_data = rd_row & low_mask(req_ff.new_output_count);
                  end
                  if (row_ff == LastRow) begin
                     live_out_in  = req_ff.new_output_count;
                     live_in_in   = req_ff.new_input_count;
                     rsp_valid_in = 1'b1;
                     rsp_data_in.last_result = 1'b1;
                     rsp_data_in.status = st_ff;
                     state_in = S_IDLE;
                  end
               end
               rcm_pkg::MODE_REM_OUT: begin
                  wr_data = (rd_row & keep_mask) | ((rd_row >> 1) & ~keep_mask);
                  if (row_ff == LastRow) begin
                     live_out_in  = live_out_ff - CntW'(1);
                     rsp_valid_in = 1'b1;
                     rsp_data_in.last_result = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  // Remove input: move the next row down, clear the old top row.
                  if (!tail_ff) begin
                     wr_data = rd_row;
                  end else begin
                     live_in_in   = live_in_ff - CntW'(1);
                     rsp_valid_in = 1'b1;
                     rsp_data_in.last_result = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end

         // Route: take the live part of the row into the shifter.
         S_RT_LOAD: begin
            shift_in = rd_row & low_mask(live_out_ff);
            col_in   = '0;
            if ((rd_row & low_mask(live_out_ff)) == '0) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.last_result = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_RT_SCAN;
            end
         end

         // Route: one column per cycle, stop after the highest connection.
         S_RT_SCAN: begin
            shift_in = shift_rest;
            col_in   = col_ff + ColAw'(1);
            if (shift_ff[0]) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.found_output = 4'(col_ff);
               rsp_data_in.found_valid  = 1'b1;
               rsp_data_in.last_result  = (shift_rest == '0);
            end
            if (shift_rest == '0) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_data_in.current_outputs = live_out_in;
      rsp_data_in.current_inputs  = live_in_in;
   end

   // Row valid bits: set on the first write of a row.
   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_out_ff  <= '0;
         live_in_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         live_out_ff  <= live_out_in;
         live_in_ff   <= live_in_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      st_ff       <= st_in;
      row_ff      <= row_in;
      tail_ff     <= tail_in;
      shift_ff    <= shift_in;
      col_ff      <= col_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Row memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= rows_mem[rd_addr];
         rd_hit_ff  <= row_valid_ff[rd_addr];
      end
   end

endmodule

@@ tb/sv/crosspoint_checker.sv @@
module crosspoint_checker #(
   parameter int MAX_OUTPUTS = rcm_pkg::DEF_MAX_OUTPUTS,
   parameter int MAX_INPUTS  = rcm_pkg::DEF_MAX_INPUTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  rcm_pkg::req_type          req_data,
   input  logic                      rsp_valid,
   input  rcm_pkg::rsp_type          rsp_data,
   output int unsigned               mismatch_count,
   output int unsigned               pending_count,
   output int unsigned               results_seen,
   output logic [rcm_pkg::CntW-1:0]  model_outputs,
   output logic [rcm_pkg::CntW-1:0]  model_inputs
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CntW = rcm_pkg::CntW;

   // Only the first mismatches are printed, all of them are counted.
   localparam int PrintLimit = 40;

   // Shadow copy of the connection matrix and the live port counts.
   logic [MAX_OUTPUTS-1:0] conn_rows [MAX_INPUTS];
   logic [CntW-1:0]        live_outputs;
   logic [CntW-1:0]        live_inputs;

   // Results predicted for accepted transactions, oldest first.
   rcm_pkg::rsp_type awaited_rsp [$];

   assign model_outputs = live_outputs;
   assign model_inputs  = live_inputs;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      results_seen   = 0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PrintLimit) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input int exp_val, input int got_val);
      if (exp_val != got_val) begin
         report_mismatch($sformatf("result %0d field %s: expected %0d, got %0d",
                                   results_seen, name, exp_val, got_val));
      end
   endtask

   // Queue one expected result; the port counts are those after the operation.
   function automatic void push_result(logic conn, logic [3:0] found, logic valid,
                                       logic last, logic [1:0] status);
      rcm_pkg::rsp_type r;
      r.connected       = conn;
      r.found_output    = found;
      r.found_valid     = valid;
      r.last_result     = last;
      r.status          = status;
      r.current_outputs = live_outputs;
      r.current_inputs  = live_inputs;
      awaited_rsp.push_back(r);
   endfunction

   // Apply one transaction to the shadow matrix and queue its results.
   function automatic void apply_matrix_op(rcm_pkg::req_type t);
      logic [CntW-1:0]        want_out;
      logic [CntW-1:0]        want_in;
      logic [1:0]             st;
      logic [MAX_OUTPUTS-1:0] keep_low;
      int                     highest;

      case (t.mode)
         rcm_pkg::MODE_SET, rcm_pkg::MODE_GET: begin
            if (t.output_index >= live_outputs || t.input_index >= live_inputs) begin
               push_result(1'b0, 4'd0, 1'b0, 1'b1, rcm_pkg::ST_RANGE);
            end else begin
               if (t.mode == rcm_pkg::MODE_SET) begin
                  conn_rows[t.input_index][t.output_index] = t.bit_value;
               end
               push_result(conn_rows[t.input_index][t.output_index], 4'd0, 1'b0, 1'b1,
                           rcm_pkg::ST_OK);
            end
         end
         rcm_pkg::MODE_RESIZE: begin
            want_out = t.new_output_count;
            want_in  = t.new_input_count;
            st       = rcm_pkg::ST_OK;
            if (want_out > MAX_OUTPUTS) begin
               want_out = CntW'(MAX_OUTPUTS);
               st       = rcm_pkg::ST_RANGE;
            end
            if (want_in > MAX_INPUTS) begin
               want_in = CntW'(MAX_INPUTS);
               st      = rcm_pkg::ST_RANGE;
            end
            // Only bits inside the new bounds survive.
            for (int r = 0; r < MAX_INPUTS; r++) begin
               for (int c = 0; c < MAX_OUTPUTS; c++) begin
                  if (r >= want_in || c >= want_out) conn_rows[r][c] = 1'b0;
               end
            end
            live_outputs = want_out;
            live_inputs  = want_in;
            push_result(1'b0, 4'd0, 1'b0, 1'b1, st);
         end
         rcm_pkg::MODE_REM_IN: begin
            if (!(live_outputs > 0 && live_inputs > 1)) begin
               push_result(1'b0, 4'd0, 1'b0, 1'b1, rcm_pkg::ST_REFUSED);
            end else if (t.input_index >= live_inputs) begin
               push_result(1'b0, 4'd0, 1'b0, 1'b1, rcm_pkg::ST_RANGE);
            end else begin
               // Higher rows move down by one and the last live row is cleared.
               for (int r = t.input_index; r + 1 < live_inputs; r++) begin
                  conn_rows[r] = conn_rows[r + 1];
               end
               conn_rows[live_inputs - 1] = '0;
               live_inputs = live_inputs - 1'b1;
               push_result(1'b0, 4'd0, 1'b0, 1'b1, rcm_pkg::ST_OK);
            end
         end
         rcm_pkg::MODE_REM_OUT: begin
            if (!(live_outputs > 1 && live_inputs > 0)) begin
               push_result(1'b0, 4'd0, 1'b0, 1'b1, rcm_pkg::ST_REFUSED);
            end else if (t.output_index >= live_outputs) begin
               push_result(1'b0, 4'd0, 1'b0, 1'b1, rcm_pkg::ST_RANGE);
            end else begin
               // Columns above the removed one shift down by one in every row.
               keep_low = (MAX_OUTPUTS'(1) << t.output_index) - 1'b1;
               for (int r = 0; r < MAX_INPUTS; r++) begin
                  conn_rows[r] = (conn_rows[r] & keep_low) |
                                 ((conn_rows[r] >> (t.output_index + 1)) << t.output_index);
               end
               live_outputs = live_outputs - 1'b1;
               push_result(1'b0, 4'd0, 1'b0, 1'b1, rcm_pkg::ST_OK);
            end
         end
         rcm_pkg::MODE_ROUTE: begin
            if (t.input_index >= live_inputs) begin
               push_result(1'b0, 4'd0, 1'b0, 1'b1, rcm_pkg::ST_RANGE);
            end else begin
               highest = -1;
               for (int c = 0; c < live_outputs; c++) begin
                  if (conn_rows[t.input_index][c]) highest = c;
               end
               if (highest < 0) begin
                  push_result(1'b0, 4'd0, 1'b0, 1'b1, rcm_pkg::ST_OK);
               end else begin
                  for (int c = 0; c <= highest; c++) begin
                     if (conn_rows[t.input_index][c]) begin
                        push_result(1'b0, 4'(c), 1'b1, c == highest, rcm_pkg::ST_OK);
                     end
                  end
               end
            end
         end
         default: begin
            push_result(1'b0, 4'd0, 1'b0, 1'b1, rcm_pkg::ST_RANGE);
         end
      endcase
   endfunction

   // Results are compared before the transaction accepted at the same edge is
   // predicted, since a result never comes in its own accept cycle.
   always @(posedge clock) begin
      rcm_pkg::rsp_type want;
      if (reset) begin
         for (int r = 0; r < MAX_INPUTS; r++) conn_rows[r] = '0;
         live_outputs = '0;
         live_inputs  = '0;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         results_seen));
            end else begin
               want = awaited_rsp.pop_front();
               compare_field("connected", int'(want.connected),
                             int'(rsp_data.connected));
               compare_field("found_output", int'(want.found_output),
                             int'(rsp_data.found_output));
               compare_field("found_valid", int'(want.found_valid),
                             int'(rsp_data.found_valid));
               compare_field("last_result", int'(want.last_result),
                             int'(rsp_data.last_result));
               compare_field("status", int'(want.status), int'(rsp_data.status));
               compare_field("current_outputs", int'(want.current_outputs),
                             int'(rsp_data.current_outputs));
               compare_field("current_inputs", int'(want.current_inputs),
                             int'(rsp_data.current_inputs));
            end
            results_seen++;
         end
         if (start && !busy) begin
            apply_matrix_op(req_data);
         end
      end
      pending_count = awaited_rsp.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CntW        = rcm_pkg::CntW;
   localparam int RandomItems = 433;
   // Longest transaction is a full row sweep; the tail wait allows for it.
   localparam int TailCycles  = 2 * rcm_pkg::DEF_MAX_INPUTS + 8;
   // Mode codes the block does not define.
   localparam logic [2:0] MODE_UNDEF_6 = 3'd6;
   localparam logic [2:0] MODE_UNDEF_7 = 3'd7;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   rcm_pkg::req_type req_data;
   logic             rsp_valid;
   rcm_pkg::rsp_type rsp_data;

   int unsigned      mismatch_count;
   int unsigned      pending_count;
   int unsigned      results_seen;
   logic [CntW-1:0]  cur_outputs;
   logic [CntW-1:0]  cur_inputs;

   int               mode_count [8];
   bit               no_idle;

   routing_crosspoint_matrix dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   crosspoint_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .results_seen   (results_seen),
      .model_outputs  (cur_outputs),
      .model_inputs   (cur_inputs)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5ms;
      $display("[routing_crosspoint_matrix] ERROR");
      $finish;
   end

   function automatic rcm_pkg::req_type make_req(logic [2:0] mode, logic [3:0] out_idx,
                                                 logic [3:0] in_idx, logic bv,
                                                 logic [CntW-1:0] n_out,
                                                 logic [CntW-1:0] n_in);
      rcm_pkg::req_type t;
      t.mode             = mode;
      t.output_index     = out_idx;
      t.input_index      = in_idx;
      t.bit_value        = bv;
      t.new_output_count = n_out;
      t.new_input_count  = n_in;
      return t;
   endfunction

   // Mostly short gaps, now and then a long one, none in a no-idle stretch.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Index inside the live range most of the time, anything otherwise.
   function automatic logic [3:0] pick_index(logic [CntW-1:0] live);
      if (live > 0 && $urandom_range(0, 99) < 88) return 4'($urandom_range(0, live - 1));
      return 4'($urandom_range(0, 15));
   endfunction

   // Port count for resize: mostly useful sizes, some zero, some saturating.
   function automatic logic [CntW-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return '0;
      if (r < 14) return CntW'($urandom_range(17, 31));
      if (r < 24) return CntW'($urandom_range(1, 3));
      return CntW'($urandom_range(4, 16));
   endfunction

   function automatic rcm_pkg::req_type random_item();
      logic [31:0]      raw;
      rcm_pkg::req_type t;
      int               pick;
      raw  = $urandom;
      t    = raw[$bits(rcm_pkg::req_type)-1:0];
      pick = $urandom_range(0, 99);
      // A small share of transactions keeps fully random fields.
      if (pick < 6) return t;
      // Grow a matrix that has shrunk too far to exercise much.
      if ((cur_inputs < 2 || cur_outputs < 2) && $urandom_range(0, 99) < 50) pick = 77;
      if (pick < 40) t.mode = rcm_pkg::MODE_SET;
      else if (pick < 55) t.mode = rcm_pkg::MODE_GET;
      else if (pick < 75) t.mode = rcm_pkg::MODE_ROUTE;
      else if (pick < 83) t.mode = rcm_pkg::MODE_RESIZE;
      else if (pick < 89) t.mode = rcm_pkg::MODE_REM_IN;
      else if (pick < 95) t.mode = rcm_pkg::MODE_REM_OUT;
      else t.mode = $urandom_range(0, 1) ? MODE_UNDEF_6 : MODE_UNDEF_7;
      t.output_index     = pick_index(cur_outputs);
      t.input_index      = pick_index(cur_inputs);
      t.new_output_count = pick_count();
      t.new_input_count  = pick_count();
      return t;
   endfunction

   // Present one transaction from a falling edge until it is accepted, then
   // idle for a random gap with random fields on the ignored request bus.
   task automatic send_item(input rcm_pkg::req_type t);
      logic [31:0] raw;
      int          gap;
      start    <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (busy);
      mode_count[t.mode]++;
      @(negedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         raw = $urandom;
         start    <= 1'b0;
         req_data <= raw[$bits(rcm_pkg::req_type)-1:0];
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      no_idle  = 1'b0;
      foreach (mode_count[m]) mode_count[m] = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Empty matrix after reset: everything is out of range or refused.
      send_item(make_req(rcm_pkg::MODE_ROUTE,   4'd0,  4'd0,  1'b0, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_SET,     4'd0,  4'd0,  1'b1, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_REM_IN,  4'd0,  4'd0,  1'b0, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_REM_OUT, 4'd0,  4'd0,  1'b0, 5'd0,  5'd0));
      // Full size, a few connections on one input, reads and routes.
      send_item(make_req(rcm_pkg::MODE_RESIZE,  4'd0,  4'd0,  1'b0, 5'd16, 5'd16));
      send_item(make_req(rcm_pkg::MODE_SET,     4'd15, 4'd0,  1'b1, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_SET,     4'd0,  4'd0,  1'b1, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_SET,     4'd7,  4'd0,  1'b1, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_GET,     4'd15, 4'd15, 1'b0, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_ROUTE,   4'd0,  4'd0,  1'b0, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_ROUTE,   4'd0,  4'd1,  1'b0, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_SET,     4'd7,  4'd0,  1'b0, 5'd0,  5'd0));
      send_item(make_req(MODE_UNDEF_6,          4'd3,  4'd3,  1'b1, 5'd3,  5'd3));
      send_item(make_req(MODE_UNDEF_7,          4'd15, 4'd15, 1'b1, 5'd31, 5'd31));
      // Saturating resize, removals at the edges, then an index just past the end.
      send_item(make_req(rcm_pkg::MODE_RESIZE,  4'd0,  4'd0,  1'b0, 5'd31, 5'd31));
      send_item(make_req(rcm_pkg::MODE_REM_OUT, 4'd0,  4'd0,  1'b0, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_REM_IN,  4'd0,  4'd15, 1'b0, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_REM_IN,  4'd0,  4'd15, 1'b0, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_ROUTE,   4'd0,  4'd0,  1'b0, 5'd0,  5'd0));
      // Zero outputs: an input removal refused and a get out of range.
      send_item(make_req(rcm_pkg::MODE_RESIZE,  4'd0,  4'd0,  1'b0, 5'd0,  5'd5));
      send_item(make_req(rcm_pkg::MODE_REM_IN,  4'd0,  4'd0,  1'b0, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_GET,     4'd0,  4'd0,  1'b0, 5'd0,  5'd0));
      // One by one: the output removal refused, a single connection routed.
      send_item(make_req(rcm_pkg::MODE_RESIZE,  4'd0,  4'd0,  1'b0, 5'd1,  5'd1));
      send_item(make_req(rcm_pkg::MODE_REM_OUT, 4'd0,  4'd0,  1'b0, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_SET,     4'd0,  4'd0,  1'b1, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_ROUTE,   4'd0,  4'd0,  1'b0, 5'd0,  5'd0));
      send_item(make_req(rcm_pkg::MODE_RESIZE,  4'd0,  4'd0,  1'b0, 5'd3,  5'd20));

      // Random transactions, with stretches of back-to-back traffic.
      for (int n = 0; n < RandomItems; n++) begin
         if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
         send_item(random_item());
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      $display("Sent %0d set, %0d get, %0d resize, %0d input removal,",
               mode_count[rcm_pkg::MODE_SET], mode_count[rcm_pkg::MODE_GET],
               mode_count[rcm_pkg::MODE_RESIZE], mode_count[rcm_pkg::MODE_REM_IN]);
      $display("%0d output removal, %0d route and %0d undefined-mode transactions; %0d results compared.",
               mode_count[rcm_pkg::MODE_REM_OUT], mode_count[rcm_pkg::MODE_ROUTE],
               mode_count[MODE_UNDEF_6] + mode_count[MODE_UNDEF_7], results_seen);
      if (mismatch_count == 0) begin
         $display("[routing_crosspoint_matrix] OK");
      end else begin
         $display("[routing_crosspoint_matrix] ERROR");
      end
      $finish;
   end

endmodule
